FILE: rtl/ktc_pkg.sv
// Shared types, codes and helpers for the kettle thermostat controller.
package ktc_pkg;

  localparam int BLINK_PERIOD_DEFAULT = 128;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 21;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_HALF_HOUR = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS          = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LIMIT        = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMER_LIMIT         = 4'd3;

  localparam logic [20:0] TICKS_PER_HALF_HOUR_RESET = 21'd367600;
  localparam logic [7:0]  HYSTERESIS_RESET          = 8'd8;
  localparam logic [6:0]  TARGET_LIMIT_RESET        = 7'd50;
  localparam logic [4:0]  TIMER_LIMIT_RESET         = 5'd19;

  localparam logic [6:0]  TARGET_RESET = 7'd40;

  // operations
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SAMPLE = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_MODE   = 3'd3;
  localparam logic [2:0] OP_UP     = 3'd4;
  localparam logic [2:0] OP_DOWN   = 3'd5;

  // run states
  localparam logic [1:0] RUN_IDLE    = 2'd0;
  localparam logic [1:0] RUN_ACTIVE  = 2'd1;
  localparam logic [1:0] RUN_DELAYED = 2'd2;

  // views
  localparam logic [1:0] VIEW_TARGET = 2'd0;
  localparam logic [1:0] VIEW_TEMP   = 2'd1;
  localparam logic [1:0] VIEW_TIMER  = 2'd2;

  // beep requests
  localparam logic [1:0] BEEP_NONE    = 2'd0;
  localparam logic [1:0] BEEP_START   = 2'd1;
  localparam logic [1:0] BEEP_STOP    = 2'd2;
  localparam logic [1:0] BEEP_REACHED = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] temperature_q4;
  } in_item_t;

  typedef struct packed {
    logic        heater_level;
    logic [6:0]  display_value;
    logic [1:0]  view_mode;
    logic        start_lamp;
    logic        warm_lamp;
    logic [1:0]  beep_count;
    logic        save_request;
  } out_item_t;

  typedef struct packed {
    logic [20:0] ticks_per_half_hour;
    logic [7:0]  hysteresis_q4;
    logic [6:0]  target_limit;
    logic [4:0]  timer_limit;
  } cfg_t;

  // values here never reach 256, so two compares do
  function automatic logic [6:0] mod100(input logic [7:0] v);
    logic [7:0] r;
    if (v >= 8'd200) begin
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      r = v - 8'd100;
    end else begin
      r = v;
    end
    return r[6:0];
  endfunction

endpackage

FILE: rtl/kettle_thermostat_controller.sv
// Kettle thermostat controller top level: input register, step logic, result register.
//
// Events (tick, temperature sample, start, mode, up, down) enter on the in_*
// channel; every accepted item gives exactly one result item on out_*, in order,
// carrying heater level, display value, view, lamps, beep and save requests.
// An item is accepted into the input register, then processed by the step logic
// into the result register once that register is free, which raises out_valid.
// One item per cycle is sustained while out_ready stays high: the input
// register takes a new item in the same cycle that the held one moves on.
// When out_ready is low the result register holds its item; the input register
// then fills and in_ready falls until the result is taken. No item is lost.
// The cfg_* channel is always ready; writes take effect on the next edge and
// belong only to idle periods. Unknown register indexes are ignored.
// rst (synchronous, active high) empties both registers, loads the register
// reset values and returns the controller to idle with target 40 degrees.
// BLINK_PERIOD sets how many ticks the start lamp stays in each phase while a
// delayed start is pending.
module kettle_thermostat_controller #(
  parameter int BLINK_PERIOD = ktc_pkg::BLINK_PERIOD_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ktc_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ktc_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ktc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ktc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic               in_full;
  ktc_pkg::in_item_t  in_hold;
  logic               step_go;
  ktc_pkg::cfg_t      cfg;
  ktc_pkg::out_item_t step_result;

  assign cfg_ready = 1'b1;
  assign step_go   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || step_go;

  ktc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ktc_step #(
    .BLINK_PERIOD (BLINK_PERIOD)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .go     (step_go),
    .item   (in_hold),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_item <= step_result;
    end
  end

endmodule

FILE: rtl/ktc_cfg_regs.sv
// Configuration register bank for the kettle thermostat controller.
module ktc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [ktc_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [ktc_pkg::CFG_DATA_W-1:0]   wr_data,
  output ktc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_half_hour <= ktc_pkg::TICKS_PER_HALF_HOUR_RESET;
      cfg.hysteresis_q4       <= ktc_pkg::HYSTERESIS_RESET;
      cfg.target_limit        <= ktc_pkg::TARGET_LIMIT_RESET;
      cfg.timer_limit         <= ktc_pkg::TIMER_LIMIT_RESET;
    end else if (wr_en) begin
      // writes to unknown indexes are dropped
      case (wr_index)
        ktc_pkg::REG_TICKS_PER_HALF_HOUR: cfg.ticks_per_half_hour <= wr_data[20:0];
        ktc_pkg::REG_HYSTERESIS:          cfg.hysteresis_q4       <= wr_data[7:0];
        ktc_pkg::REG_TARGET_LIMIT:        cfg.target_limit        <= wr_data[6:0];
        ktc_pkg::REG_TIMER_LIMIT:         cfg.timer_limit         <= wr_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/ktc_step.sv
// Controller state and the single-pass next-state and result logic.
module ktc_step #(
  parameter int BLINK_PERIOD = ktc_pkg::BLINK_PERIOD_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  ktc_pkg::in_item_t  item,
  input  ktc_pkg::cfg_t      cfg,
  output ktc_pkg::out_item_t result
);

  localparam int BW = (BLINK_PERIOD > 1) ? $clog2(BLINK_PERIOD) : 1;
  localparam logic [BW:0] BLINK_END = (BW+1)'(BLINK_PERIOD);

  logic [1:0]    run_state,        run_state_next;
  logic [1:0]    current_view,     current_view_next;
  logic [6:0]    target_deg,       target_deg_next;
  logic [11:0]   last_temperature, last_temperature_next;
  logic          over_flag,        over_flag_next;
  logic          keep_warm,        keep_warm_next;
  logic [4:0]    delay_steps,      delay_steps_next;
  logic [20:0]   elapsed_ticks,    elapsed_ticks_next;
  logic [BW-1:0] blink_ticks,      blink_ticks_next;
  logic          start_led_level,  start_led_level_next;
  logic          heater_state,     heater_state_next;

  logic          regulate_en;
  logic [12:0]   goal;
  logic [1:0]    beep;
  logic          save;
  logic [6:0]    shown;

  always_comb begin
    run_state_next        = run_state;
    current_view_next     = current_view;
    target_deg_next       = target_deg;
    last_temperature_next = last_temperature;
    over_flag_next        = over_flag;
    keep_warm_next        = keep_warm;
    delay_steps_next      = delay_steps;
    elapsed_ticks_next    = elapsed_ticks;
    blink_ticks_next      = blink_ticks;
    start_led_level_next  = start_led_level;
    heater_state_next     = heater_state;
    regulate_en           = 1'b0;
    beep                  = ktc_pkg::BEEP_NONE;
    save                  = 1'b0;

    unique case (item.operation)
      ktc_pkg::OP_TICK: begin
        if (run_state == ktc_pkg::RUN_DELAYED) begin
          if ({1'b0, elapsed_ticks} + 22'd1 >= {1'b0, cfg.ticks_per_half_hour}) begin
            elapsed_ticks_next = '0;
            if (delay_steps != 5'd0) begin
              delay_steps_next = delay_steps - 5'd1;
            end
            if (delay_steps_next == 5'd0) begin
              run_state_next       = ktc_pkg::RUN_ACTIVE;
              start_led_level_next = 1'b1;
            end
          end else begin
            elapsed_ticks_next = elapsed_ticks + 21'd1;
          end
          // blink keeps going on the tick that ends the delay
          if ({1'b0, blink_ticks} + {{BW{1'b0}}, 1'b1} >= BLINK_END) begin
            blink_ticks_next     = '0;
            start_led_level_next = ~start_led_level_next;
          end else begin
            blink_ticks_next = blink_ticks + BW'(1);
          end
        end
      end
      ktc_pkg::OP_SAMPLE: begin
        last_temperature_next = item.temperature_q4;
        regulate_en           = 1'b1;
      end
      ktc_pkg::OP_START: begin
        if (run_state == ktc_pkg::RUN_IDLE) begin
          if (delay_steps == 5'd0) begin
            run_state_next = ktc_pkg::RUN_ACTIVE;
          end else begin
            run_state_next     = ktc_pkg::RUN_DELAYED;
            elapsed_ticks_next = '0;
          end
          beep                 = ktc_pkg::BEEP_START;
          start_led_level_next = 1'b1;
        end else begin
          run_state_next       = ktc_pkg::RUN_IDLE;
          beep                 = ktc_pkg::BEEP_STOP;
          keep_warm_next       = 1'b0;
          start_led_level_next = 1'b0;
        end
        regulate_en = 1'b1;
      end
      ktc_pkg::OP_MODE: begin
        unique case (current_view)
          ktc_pkg::VIEW_TARGET: current_view_next = ktc_pkg::VIEW_TEMP;
          ktc_pkg::VIEW_TEMP:   current_view_next = ktc_pkg::VIEW_TIMER;
          default:              current_view_next = ktc_pkg::VIEW_TARGET;
        endcase
      end
      ktc_pkg::OP_UP: begin
        if (current_view == ktc_pkg::VIEW_TARGET) begin
          if (target_deg < cfg.target_limit) begin
            target_deg_next = target_deg + 7'd1;
            save            = 1'b1;
          end
        end else if (current_view == ktc_pkg::VIEW_TIMER) begin
          if (delay_steps < cfg.timer_limit) begin
            delay_steps_next = delay_steps + 5'd1;
          end
        end
      end
      ktc_pkg::OP_DOWN: begin
        if (current_view == ktc_pkg::VIEW_TARGET) begin
          if (target_deg != 7'd0) begin
            target_deg_next = target_deg - 7'd1;
            save            = 1'b1;
          end
        end else if (current_view == ktc_pkg::VIEW_TIMER) begin
          if (delay_steps != 5'd0) begin
            delay_steps_next = delay_steps - 5'd1;
          end
        end
      end
      default: ;
    endcase

    // bang-bang with hysteresis, on the state left by the event
    goal = {2'b00, target_deg_next, 4'b0000};
    if (regulate_en) begin
      if (run_state_next != ktc_pkg::RUN_ACTIVE) begin
        heater_state_next = 1'b0;
      end else if (over_flag_next) begin
        if ({1'b0, last_temperature_next} <= goal) begin
          heater_state_next = 1'b1;
          over_flag_next    = 1'b0;
        end else begin
          heater_state_next = 1'b0;
        end
      end else begin
        if ({1'b0, last_temperature_next} <= goal + {5'd0, cfg.hysteresis_q4}) begin
          heater_state_next = 1'b1;
        end else begin
          heater_state_next = 1'b0;
          over_flag_next    = 1'b1;
        end
      end
    end

    // first pass of the target while running: alarm and keep-warm
    if (item.operation == ktc_pkg::OP_SAMPLE && run_state_next == ktc_pkg::RUN_ACTIVE &&
        over_flag_next && !keep_warm_next) begin
      beep           = ktc_pkg::BEEP_REACHED;
      keep_warm_next = 1'b1;
    end

    unique case (current_view_next)
      ktc_pkg::VIEW_TARGET: shown = ktc_pkg::mod100({1'b0, target_deg_next});
      ktc_pkg::VIEW_TEMP:   shown = ktc_pkg::mod100(last_temperature_next[11:4]);
      ktc_pkg::VIEW_TIMER:  shown = ktc_pkg::mod100({3'b000, delay_steps_next} * 8'd5);
      default:              shown = 7'd0;
    endcase
  end

  always_comb begin
    result.heater_level  = heater_state_next;
    result.display_value = shown;
    result.view_mode     = current_view_next;
    result.start_lamp    = start_led_level_next;
    result.warm_lamp     = keep_warm_next;
    result.beep_count    = beep;
    result.save_request  = save;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state        <= ktc_pkg::RUN_IDLE;
      current_view     <= ktc_pkg::VIEW_TARGET;
      target_deg       <= ktc_pkg::TARGET_RESET;
      last_temperature <= '0;
      over_flag        <= 1'b0;
      keep_warm        <= 1'b0;
      delay_steps      <= '0;
      elapsed_ticks    <= '0;
      blink_ticks      <= '0;
      start_led_level  <= 1'b0;
      heater_state     <= 1'b0;
    end else if (go) begin
      run_state        <= run_state_next;
      current_view     <= current_view_next;
      target_deg       <= target_deg_next;
      last_temperature <= last_temperature_next;
      over_flag        <= over_flag_next;
      keep_warm        <= keep_warm_next;
      delay_steps      <= delay_steps_next;
      elapsed_ticks    <= elapsed_ticks_next;
      blink_ticks      <= blink_ticks_next;
      start_led_level  <= start_led_level_next;
      heater_state     <= heater_state_next;
    end
  end

endmodule

FILE: sim/tb_kettle_thermostat_controller.sv
// Self-checking testbench for the kettle thermostat controller: event streams against a model.
module tb_kettle_thermostat_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLINK = ktc_pkg::BLINK_PERIOD_DEFAULT;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ktc_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ktc_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ktc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ktc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // controller state as predicted
  logic [1:0] m_run;
  logic [1:0] m_view;
  logic [6:0] m_target;
  logic [11:0] m_temp;
  logic m_over;
  logic m_warm;
  logic [4:0] m_delay;
  logic [20:0] m_elapsed;
  logic [6:0] m_blink;
  logic m_lamp;
  logic m_heat;

  // register copies
  logic [20:0] c_tph;
  logic [7:0] c_hyst;
  logic [6:0] c_tlim;
  logic [4:0] c_timlim;

  ktc_pkg::in_item_t ev_q[$];
  int ev_gap_q[$];
  ktc_pkg::out_item_t status_due[$];
  ktc_pkg::out_item_t due_now;

  int mismatches = 0;
  int results_seen = 0;
  int items_made = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  kettle_thermostat_controller u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void model_reset();
    c_tph = ktc_pkg::TICKS_PER_HALF_HOUR_RESET;
    c_hyst = ktc_pkg::HYSTERESIS_RESET;
    c_tlim = ktc_pkg::TARGET_LIMIT_RESET;
    c_timlim = ktc_pkg::TIMER_LIMIT_RESET;
    m_run = ktc_pkg::RUN_IDLE;
    m_view = ktc_pkg::VIEW_TARGET;
    m_target = ktc_pkg::TARGET_RESET;
    m_temp = '0;
    m_over = 1'b0;
    m_warm = 1'b0;
    m_delay = '0;
    m_elapsed = '0;
    m_blink = '0;
    m_lamp = 1'b0;
    m_heat = 1'b0;
  endfunction

  // bang-bang with overshoot band; over flag holds the heater off until back at target
  function automatic void regulate_heater();
    int goal;
    goal = int'(m_target) * 16;
    if (m_run != ktc_pkg::RUN_ACTIVE) begin
      m_heat = 1'b0;
    end else if (m_over) begin
      if (int'(m_temp) <= goal) begin
        m_heat = 1'b1;
        m_over = 1'b0;
      end else begin
        m_heat = 1'b0;
      end
    end else if (int'(m_temp) <= goal + int'(c_hyst)) begin
      m_heat = 1'b1;
    end else begin
      m_heat = 1'b0;
      m_over = 1'b1;
    end
  endfunction

  function automatic void delay_tick();
    if (m_run != ktc_pkg::RUN_DELAYED) begin
      return;
    end
    if (int'(m_elapsed) + 1 >= int'(c_tph)) begin
      m_elapsed = '0;
      if (m_delay != 0) begin
        m_delay = m_delay - 5'd1;
      end
      if (m_delay == 0) begin
        m_run = ktc_pkg::RUN_ACTIVE;
        m_lamp = 1'b1;
      end
    end else begin
      m_elapsed = m_elapsed + 21'd1;
    end
    // blink still advances on the tick that ends the delay
    if (int'(m_blink) + 1 >= BLINK) begin
      m_blink = '0;
      m_lamp = ~m_lamp;
    end else begin
      m_blink = m_blink + 7'd1;
    end
  endfunction

  function automatic ktc_pkg::out_item_t kettle_step(input ktc_pkg::in_item_t ev);
    ktc_pkg::out_item_t r;
    logic [1:0] beep;
    logic save;
    int shown;
    beep = ktc_pkg::BEEP_NONE;
    save = 1'b0;
    case (ev.operation)
      ktc_pkg::OP_TICK: begin
        delay_tick();
      end
      ktc_pkg::OP_SAMPLE: begin
        m_temp = ev.temperature_q4;
        regulate_heater();
        if (m_run == ktc_pkg::RUN_ACTIVE && m_over && !m_warm) begin
          beep = ktc_pkg::BEEP_REACHED;
          m_warm = 1'b1;
        end
      end
      ktc_pkg::OP_START: begin
        if (m_run == ktc_pkg::RUN_IDLE) begin
          if (m_delay == 0) begin
            m_run = ktc_pkg::RUN_ACTIVE;
          end else begin
            m_run = ktc_pkg::RUN_DELAYED;
            m_elapsed = '0;
          end
          beep = ktc_pkg::BEEP_START;
          m_lamp = 1'b1;
        end else begin
          m_run = ktc_pkg::RUN_IDLE;
          beep = ktc_pkg::BEEP_STOP;
          m_warm = 1'b0;
          m_lamp = 1'b0;
        end
        regulate_heater();
      end
      ktc_pkg::OP_MODE: begin
        m_view = (m_view == ktc_pkg::VIEW_TARGET) ? ktc_pkg::VIEW_TEMP :
                 (m_view == ktc_pkg::VIEW_TEMP) ? ktc_pkg::VIEW_TIMER : ktc_pkg::VIEW_TARGET;
      end
      ktc_pkg::OP_UP: begin
        if (m_view == ktc_pkg::VIEW_TARGET) begin
          if (m_target < c_tlim) begin
            m_target = m_target + 7'd1;
            save = 1'b1;
          end
        end else if (m_view == ktc_pkg::VIEW_TIMER) begin
          if (m_delay < c_timlim) begin
            m_delay = m_delay + 5'd1;
          end
        end
      end
      ktc_pkg::OP_DOWN: begin
        if (m_view == ktc_pkg::VIEW_TARGET) begin
          if (m_target > 0) begin
            m_target = m_target - 7'd1;
            save = 1'b1;
          end
        end else if (m_view == ktc_pkg::VIEW_TIMER) begin
          if (m_delay > 0) begin
            m_delay = m_delay - 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
    case (m_view)
      ktc_pkg::VIEW_TARGET: shown = int'(m_target) % 100;
      ktc_pkg::VIEW_TEMP: shown = int'(m_temp >> 4) % 100;
      ktc_pkg::VIEW_TIMER: shown = (int'(m_delay) * 5) % 100;
      default: shown = 0;
    endcase
    r.heater_level = m_heat;
    r.display_value = shown[6:0];
    r.view_mode = m_view;
    r.start_lamp = m_lamp;
    r.warm_lamp = m_warm;
    r.beep_count = beep;
    r.save_request = save;
    return r;
  endfunction

  // driver: the next item goes out once its own gap has run down
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        status_due.push_back(kettle_step(in_item));
      end
      if (!in_valid || in_ready) begin
        if (ev_q.size() != 0 && ev_gap_q[0] == 0) begin
          in_item <= ev_q.pop_front();
          void'(ev_gap_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          if (ev_q.size() != 0) begin
            ev_gap_q[0] = ev_gap_q[0] - 1;
          end
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
      end
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: no item expected, got %h", results_seen, out_item);
          end
        end else begin
          due_now = status_due.pop_front();
          note_field("heater_level", due_now.heater_level, out_item.heater_level);
          note_field("display_value", due_now.display_value, out_item.display_value);
          note_field("view_mode", due_now.view_mode, out_item.view_mode);
          note_field("start_lamp", due_now.start_lamp, out_item.start_lamp);
          note_field("warm_lamp", due_now.warm_lamp, out_item.warm_lamp);
          note_field("beep_count", due_now.beep_count, out_item.beep_count);
          note_field("save_request", due_now.save_request, out_item.save_request);
        end
        stall_left = no_idle ? 0 : int'($urandom_range(0, 15));
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  task automatic push_ev(input logic [2:0] op, input logic [11:0] t);
    ktc_pkg::in_item_t ev;
    ev.operation = op;
    ev.temperature_q4 = t;
    ev_q.push_back(ev);
    ev_gap_q.push_back(no_idle ? 0 : int'($urandom_range(0, 15)));
    if (op <= ktc_pkg::OP_DOWN) begin
      items_made++;
    end
  endtask

  // sample near the heating band, now and then anywhere
  function automatic logic [11:0] near_goal(input int tgt);
    int t;
    t = tgt * 16 + int'($urandom_range(0, int'(c_hyst) + 48)) - 24;
    if ($urandom_range(0, 7) == 0) begin
      t = int'($urandom_range(0, 4095));
    end
    if (t < 0) begin
      t = 0;
    end
    if (t > 4095) begin
      t = 4095;
    end
    return t[11:0];
  endfunction

  // the sequences below read the model, so the stream must be fully taken first
  task automatic wait_accepted();
    while (ev_q.size() != 0 || in_valid) begin
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (ev_q.size() != 0 || in_valid || status_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic seek_view(input logic [1:0] want);
    int n;
    n = (int'(want) - int'(m_view) + 3) % 3;
    repeat (n) push_ev(ktc_pkg::OP_MODE, 12'($urandom));
  endtask

  task automatic set_config(input logic [20:0] tph, input logic [7:0] hyst,
                            input logic [6:0] tlim, input logic [4:0] timlim);
    logic [ktc_pkg::CFG_INDEX_W-1:0] idx;
    logic [ktc_pkg::CFG_DATA_W-1:0] val;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: begin
          idx = ktc_pkg::REG_TICKS_PER_HALF_HOUR;
          val = tph;
        end
        1: begin
          idx = ktc_pkg::REG_HYSTERESIS;
          val = 21'(hyst);
        end
        2: begin
          idx = ktc_pkg::REG_TARGET_LIMIT;
          val = 21'(tlim);
        end
        default: begin
          idx = ktc_pkg::REG_TIMER_LIMIT;
          val = 21'(timlim);
        end
      endcase
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    c_tph = tph;
    c_hyst = hyst;
    c_tlim = tlim;
    c_timlim = timlim;
    @(negedge clk);
  endtask

  // set a delay, start, then tick through the wait with the odd sample or early stop
  task automatic seq_delayed(input int room);
    int d;
    int ticks;
    bit cut;
    if (m_run != ktc_pkg::RUN_IDLE) begin
      push_ev(ktc_pkg::OP_START, 12'($urandom));
    end
    seek_view(ktc_pkg::VIEW_TIMER);
    d = int'(m_delay);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        push_ev(ktc_pkg::OP_DOWN, 12'($urandom));
        if (d > 0) begin
          d--;
        end
      end else begin
        push_ev(ktc_pkg::OP_UP, 12'($urandom));
        if (d < int'(c_timlim)) begin
          d++;
        end
      end
    end
    push_ev(ktc_pkg::OP_START, 12'($urandom));
    ticks = d * ((c_tph == 0) ? 1 : int'(c_tph)) + int'($urandom_range(0, 160));
    if (ticks > 300) begin
      ticks = 300;
    end
    // keep the phase close to its item budget
    if (ticks > room) begin
      ticks = room;
    end
    cut = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < ticks; i++) begin
      if (cut && i == ticks / 2) begin
        push_ev(ktc_pkg::OP_START, 12'($urandom));
      end else if ($urandom_range(0, 11) == 0) begin
        push_ev(ktc_pkg::OP_SAMPLE, near_goal(int'(m_target)));
      end else begin
        push_ev(ktc_pkg::OP_TICK, 12'($urandom));
      end
    end
    repeat ($urandom_range(0, 10)) push_ev(ktc_pkg::OP_SAMPLE, near_goal(int'(m_target)));
  endtask

  // clear the delay, nudge the target, start and feed samples around it
  task automatic seq_heating();
    int tgt;
    if (m_run != ktc_pkg::RUN_IDLE) begin
      push_ev(ktc_pkg::OP_START, 12'($urandom));
    end
    seek_view(ktc_pkg::VIEW_TIMER);
    repeat (int'(m_delay)) push_ev(ktc_pkg::OP_DOWN, 12'($urandom));
    push_ev(ktc_pkg::OP_MODE, 12'($urandom));
    tgt = int'(m_target);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1) == 0) begin
        push_ev(ktc_pkg::OP_DOWN, 12'($urandom));
        if (tgt > 0) begin
          tgt--;
        end
      end else begin
        push_ev(ktc_pkg::OP_UP, 12'($urandom));
        if (tgt < int'(c_tlim)) begin
          tgt++;
        end
      end
    end
    push_ev(ktc_pkg::OP_START, 12'($urandom));
    repeat ($urandom_range(8, 30)) begin
      if ($urandom_range(0, 9) == 0) begin
        push_ev(ktc_pkg::OP_MODE, 12'($urandom));
      end else begin
        push_ev(ktc_pkg::OP_SAMPLE, near_goal(tgt));
      end
    end
    if ($urandom_range(0, 1) == 0) begin
      push_ev(ktc_pkg::OP_START, 12'($urandom));
    end
  endtask

  task automatic seq_mash(input bit any_op);
    repeat ($urandom_range(4, 16)) begin
      if (any_op) begin
        push_ev(3'($urandom), 12'($urandom));
      end else begin
        push_ev(3'($urandom_range(ktc_pkg::OP_START, ktc_pkg::OP_DOWN)), 12'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    int pick;
    stop_at = items_made + budget;
    while (items_made < stop_at) begin
      wait_accepted();
      pick = int'($urandom_range(0, 9));
      if (pick < 4) begin
        seq_delayed(stop_at - items_made);
      end else if (pick < 7) begin
        seq_heating();
      end else if (pick < 9) begin
        seq_mash(1'b0);
      end else begin
        seq_mash(1'b1);
      end
    end
    wait_drained();
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: register reset values, target 40, band 640..648
    push_ev(ktc_pkg::OP_SAMPLE, 12'd0);
    push_ev(OP_RSVD6, 12'hFFF);
    push_ev(OP_RSVD7, 12'hFFF);
    push_ev(ktc_pkg::OP_UP, 12'd0);
    push_ev(ktc_pkg::OP_DOWN, 12'd0);
    push_ev(ktc_pkg::OP_START, 12'd0);
    push_ev(ktc_pkg::OP_SAMPLE, 12'd648);
    push_ev(ktc_pkg::OP_SAMPLE, 12'd649);
    push_ev(ktc_pkg::OP_SAMPLE, 12'd641);
    push_ev(ktc_pkg::OP_SAMPLE, 12'd640);
    push_ev(ktc_pkg::OP_SAMPLE, 12'hFFF);
    push_ev(ktc_pkg::OP_START, 12'd0);
    push_ev(ktc_pkg::OP_MODE, 12'd0);
    push_ev(ktc_pkg::OP_UP, 12'd0);
    push_ev(ktc_pkg::OP_DOWN, 12'd0);
    push_ev(ktc_pkg::OP_MODE, 12'd0);
    push_ev(ktc_pkg::OP_UP, 12'd0);
    push_ev(ktc_pkg::OP_UP, 12'd0);
    push_ev(ktc_pkg::OP_DOWN, 12'd0);
    push_ev(ktc_pkg::OP_START, 12'd0);
    push_ev(ktc_pkg::OP_TICK, 12'd0);
    push_ev(ktc_pkg::OP_START, 12'd0);
    push_ev(ktc_pkg::OP_MODE, 12'd0);
    push_ev(ktc_pkg::OP_TICK, 12'hFFF);
    wait_drained();

    // zero tick count: every tick is a delay step
    no_idle = 1'b1;
    set_config(21'd0, 8'd0, 7'd99, 5'd19);
    run_phase(120);
    no_idle = 1'b0;
    set_config(21'd1, 8'd255, 7'd0, 5'd0);
    run_phase(120);
    set_config(21'h1FFFFF, 8'd8, 7'd50, 5'd19);
    run_phase(120);
    repeat (3) begin
      no_idle = ($urandom_range(0, 2) == 0);
      set_config(21'($urandom_range(1, 24)), 8'($urandom), 7'($urandom_range(0, 99)),
                 5'($urandom_range(0, 19)));
      run_phase(120);
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("tb_kettle_thermostat_controller: done, clean");
    end else begin
      $display("tb_kettle_thermostat_controller: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_kettle_thermostat_controller: done, errors");
    $finish;
  end

endmodule
